// File: hdl/pcf_pkg.sv
// shared types, constants and helpers of the playfair digraph cipher unit
package pcf_pkg;

    localparam int LETTER_W   = 5;
    localparam int SIDE       = 5;
    localparam int POS_W      = 3;
    localparam int ROW_W      = SIDE * LETTER_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [LETTER_W-1:0] FILLER    = 5'd23;
    localparam logic [LETTER_W-1:0] FOLD_FROM = 5'd9;
    localparam logic [LETTER_W-1:0] FOLD_TO   = 5'd8;
    localparam logic [POS_W-1:0]    POS_FIRST = 3'd0;
    localparam logic [POS_W-1:0]    POS_LAST  = 3'd4;
    localparam logic [QCNT_W-1:0]   QCNT_FULL = 3'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT,
        CFG_ROW0,
        CFG_ROW1,
        CFG_ROW2,
        CFG_ROW3,
        CFG_ROW4
    } t_cfg_idx;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [POS_W-1:0]    t_pos;
    typedef t_letter [SIDE-1:0]  t_row;
    typedef t_row [SIDE-1:0]     t_square;

    // one letter pair handed from the front to the back
    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    last;
    } t_pair;

    // reset square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
    localparam t_square SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                        25'd10755269, 25'd4294688};

    // one step right/down when encrypting, left/up when decrypting, wrapping
    function automatic t_pos pos_step(input t_pos p, input logic dec);
        t_pos r;
        if (dec) begin
            r = (p == POS_FIRST) ? POS_LAST : p - 3'd1;
        end else begin
            r = (p == POS_LAST) ? POS_FIRST : p + 3'd1;
        end
        return r;
    endfunction

endpackage

// File: hdl/pcf_front.sv
// front end: folds letters, forms pairs and inserts filler letters
module pcf_front import pcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_decrypt,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_letter i_letter,
    input  logic    i_final,
    output logic    o_push,
    output t_pair   o_pair,
    input  logic    i_full
);

    logic    r_held_valid, n_held_valid;
    t_letter r_held_letter, n_held_letter;
    logic    r_pend_valid, n_pend_valid;
    t_pair   r_pend, n_pend;
    t_letter w_lt;
    logic    w_acc;

    assign w_lt    = (i_letter == FOLD_FROM) ? FOLD_TO : i_letter;
    assign o_ready = !r_pend_valid && !i_full;
    assign w_acc   = i_valid && o_ready;

    // pairing rules, at most one pair pushed per cycle, a second one waits
    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_pend_valid  = r_pend_valid;
        n_pend        = r_pend;
        o_push        = 1'b0;
        o_pair        = r_pend;
        if (r_pend_valid) begin
            if (!i_full) begin
                o_push       = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (w_acc) begin
            if (!r_held_valid) begin
                if (i_final) begin
                    o_push = 1'b1;
                    o_pair = '{first: w_lt, second: FILLER, last: 1'b1};
                end else begin
                    n_held_valid  = 1'b1;
                    n_held_letter = w_lt;
                end
            end else if (!i_decrypt && (r_held_letter == w_lt)) begin
                // doubled letter: send it with filler, second letter starts next pair
                o_push = 1'b1;
                o_pair = '{first: r_held_letter, second: FILLER, last: 1'b0};
                if (i_final) begin
                    n_pend_valid = 1'b1;
                    n_pend       = '{first: w_lt, second: FILLER, last: 1'b1};
                    n_held_valid = 1'b0;
                end
            end else begin
                o_push       = 1'b1;
                o_pair       = '{first: r_held_letter, second: w_lt, last: i_final};
                n_held_valid = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_held_letter <= n_held_letter;
        r_pend        <= n_pend;
    end

endmodule

// File: hdl/pcf_queue.sv
// short pair queue between front and back
module pcf_queue import pcf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_full,
    output logic  o_valid,
    output t_pair o_pair,
    input  logic  i_pop
);

    t_pair              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_pair  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/pcf_back.sv
// back end: locates the pair in the square and applies the cipher rules
module pcf_back import pcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_decrypt,
    input  t_square i_square,
    input  logic    i_valid,
    input  t_pair   i_pair,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_letter o_first,
    output t_letter o_second,
    output logic    o_present,
    output logic    o_last
);

    logic    r_s1_valid;
    t_pos    r_ra, r_ca, r_rb, r_cb;
    logic    r_s1_last;
    logic    r_out_valid;
    t_letter r_first, r_second;
    logic    r_present, r_last;

    t_pos    w_ra, w_ca, w_rb, w_cb;
    t_letter w_oa, w_ob;
    logic    w_out_load, w_s1_load;

    assign w_out_load = !r_out_valid || i_ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_pop      = i_valid && w_s1_load;

    // position search: 25 parallel compares per letter, last match in row-major order wins
    always_comb begin
        w_ra = POS_FIRST;
        w_ca = POS_FIRST;
        w_rb = POS_FIRST;
        w_cb = POS_FIRST;
        for (int i = 0; i < SIDE; i++) begin
            for (int k = 0; k < SIDE; k++) begin
                if (i_square[i][k] == i_pair.first) begin
                    w_ra = POS_W'(i);
                    w_ca = POS_W'(k);
                end
                if (i_square[i][k] == i_pair.second) begin
                    w_rb = POS_W'(i);
                    w_cb = POS_W'(k);
                end
            end
        end
    end

    // same row, same column or rectangle
    always_comb begin
        if (r_ra == r_rb) begin
            w_oa = i_square[r_ra][pos_step(r_ca, i_decrypt)];
            w_ob = i_square[r_rb][pos_step(r_cb, i_decrypt)];
        end else if (r_ca == r_cb) begin
            w_oa = i_square[pos_step(r_ra, i_decrypt)][r_ca];
            w_ob = i_square[pos_step(r_rb, i_decrypt)][r_cb];
        end else begin
            w_oa = i_square[r_ra][r_cb];
            w_ob = i_square[r_rb][r_ca];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ra      <= w_ra;
            r_ca      <= w_ca;
            r_rb      <= w_rb;
            r_cb      <= w_cb;
            r_s1_last <= i_pair.last;
        end
        if (w_out_load && r_s1_valid) begin
            r_first   <= w_oa;
            r_second  <= w_ob;
            r_present <= !(i_decrypt && r_s1_last && (w_ob == FILLER));
            r_last    <= r_s1_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_first   = r_first;
    assign o_second  = r_second;
    assign o_present = r_present;
    assign o_last    = r_last;

endmodule

// File: hdl/playfair_digraph_cipher_unit.sv
// top level of the playfair digraph cipher unit
//
// Letters (a=0 .. z=25, j folds to i) enter on the s_axis channel, one item
// per letter, tlast marking the final letter of a message. Letter pairs leave
// on the m_axis channel: tdata holds the two transformed letters, tuser says
// whether the second letter is present (0 when decryption drops a trailing x),
// tlast marks the final pair. The cfg port writes the mode bit and the five
// square rows; write it only while no message is in flight.
// Throughput: one letter per cycle while s_axis_tready is high. A doubled
// final letter in encrypt mode yields two pairs and holds s_axis_tready low
// while the second pair waits to enter the queue.
// A pair completed by an accepted letter is written into the queue, then passes
// the square search stage and the cipher rule stage before it is valid on m_axis.
// Reset clears the held letter, the pair queue and both back-end stages, and
// loads the default square in encrypt mode.
// When m_axis_tready is low, the output register holds; the back end and the
// four-entry queue keep filling, and s_axis_tready drops once the queue is full.
module playfair_digraph_cipher_unit import pcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [4:0] letter
    input  logic                  s_axis_tlast,   // final_letter
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [4:0] first_out, [9:5] second_out
    output logic                  m_axis_tuser,   // second_present
    output logic                  m_axis_tlast,   // end_of_message
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_decrypt;
    t_square r_square;
    logic    w_push, w_full, w_qvalid, w_pop;
    t_pair   w_push_pair, w_head;
    t_letter w_first, w_second;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_square  <= SQUARE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DECRYPT: r_decrypt   <= i_cfg_data[0];
                CFG_ROW0:    r_square[0] <= i_cfg_data;
                CFG_ROW1:    r_square[1] <= i_cfg_data;
                CFG_ROW2:    r_square[2] <= i_cfg_data;
                CFG_ROW3:    r_square[3] <= i_cfg_data;
                CFG_ROW4:    r_square[4] <= i_cfg_data;
                default:     r_decrypt   <= r_decrypt;
            endcase
        end
    end

    pcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_decrypt(r_decrypt),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_letter (s_axis_tdata[LETTER_W-1:0]),
        .i_final  (s_axis_tlast),
        .o_push   (w_push),
        .o_pair   (w_push_pair),
        .i_full   (w_full)
    );

    pcf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pair (w_push_pair),
        .o_full (w_full),
        .o_valid(w_qvalid),
        .o_pair (w_head),
        .i_pop  (w_pop)
    );

    pcf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_decrypt(r_decrypt),
        .i_square (r_square),
        .i_valid  (w_qvalid),
        .i_pair   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_first  (w_first),
        .o_second (w_second),
        .o_present(m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = {6'd0, w_second, w_first};

endmodule

// File: hdl/pcf_checker.sv
// port-level checks of the playfair digraph cipher unit and their binding
module pcf_checker import pcf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // a dropped second letter only happens on the final pair
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("second letter dropped before end of message");

    // a dropped second letter is always the filler
    a_drop_filler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[9:5] == FILLER)
        else $error("dropped second letter is not the filler");

endmodule

bind playfair_digraph_cipher_unit pcf_checker u_pcf_checker (.*);
